// ----- design/nls_pkg.sv -----
// Package with the shared types and character constants of the numeric literal scanner.
`timescale 1ns / 1ps

package nls_pkg;

   // Scanner phases
   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_ZERO    = 4'd1,
      PH_INT     = 4'd2,
      PH_DOT     = 4'd3,
      PH_FRAC    = 4'd4,
      PH_EXP     = 4'd5,
      PH_EXPSIGN = 4'd6,
      PH_EXPDIG  = 4'd7,
      PH_PREFIX  = 4'd8
   } phase_type;

   // Radix codes as reported on the result channel
   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_BIN = 2'd2,
      RADIX_OCT = 2'd3
   } radix_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_INT             = 3'd0,
      ST_FLOAT           = 3'd1,
      ST_NO_DIGITS       = 3'd2,
      ST_ONLY_UNDERSCORE = 3'd3,
      ST_OVERFLOW        = 3'd4,
      ST_NO_EXP_DIGITS   = 3'd5
   } status_type;

   localparam int ACC_W = 64;
   localparam int LEN_W = 8;

   // Held-back counts
   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_ONE  = 2'd1;
   localparam logic [1:0] HELD_TWO  = 2'd2;

   // Character codes
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LF     = 8'h66;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UF     = 8'h46;
   localparam logic [7:0] CH_LX     = 8'h78;
   localparam logic [7:0] CH_UX     = 8'h58;
   localparam logic [7:0] CH_LB     = 8'h62;
   localparam logic [7:0] CH_UB     = 8'h42;
   localparam logic [7:0] CH_LO     = 8'h6F;
   localparam logic [7:0] CH_UO     = 8'h4F;
   localparam logic [7:0] CH_LE     = 8'h65;
   localparam logic [7:0] CH_UE     = 8'h45;
   localparam logic [7:0] CH_USCORE = 8'h5F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;

   // Architectural state of the scanner
   typedef struct packed {
      phase_type          phase;
      radix_type          radix;
      logic [ACC_W-1:0]   acc;
      logic               ovf;
      logic               dseen;
      logic [LEN_W-1:0]   count;
   } nls_state_type;

   localparam nls_state_type STATE_CLEAR = '{
      phase: PH_IDLE, radix: RADIX_DEC, acc: '0, ovf: 1'b0, dseen: 1'b0, count: '0};

   // One result item
   typedef struct packed {
      status_type         status;
      radix_type          radix;
      logic [ACC_W-1:0]   value;
      logic [LEN_W-1:0]   length;
      logic [1:0]         held;
   } nls_result_type;

endpackage

// ----- design/nls_if.sv -----
// Valid/ready channel interfaces for the request and response sides of the scanner.
`timescale 1ns / 1ps

interface nls_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_flag;

   modport source (output valid, output char_code, output end_flag, input ready);
   modport sink   (input valid, input char_code, input end_flag, output ready);
endinterface

interface nls_rsp_if;
   import nls_pkg::*;

   logic                 valid;
   logic                 ready;
   status_type           status;
   radix_type            radix_code;
   logic [ACC_W-1:0]     int_value;
   logic [LEN_W-1:0]     literal_length;
   logic [1:0]           held_back;

   modport source (output valid, output status, output radix_code, output int_value,
                   output literal_length, output held_back, input ready);
   modport sink   (input valid, input status, input radix_code, input int_value,
                   input literal_length, input held_back, output ready);
endinterface

// ----- design/nls_step.sv -----
// Combinational next-state and result logic for one character of the scanner.
`timescale 1ns / 1ps

module nls_step (
   input  nls_pkg::nls_state_type  cur_state,
   input  logic [7:0]              char_code,
   input  logic                    end_flag,
   input  logic [7:0]              len_cap,
   output nls_pkg::nls_state_type  nxt_state,
   output logic                    emit,
   output nls_pkg::nls_result_type result
);
   import nls_pkg::*;

   // Actions decoded from the phase and the character
   typedef struct packed {
      logic [1:0]  bump;
      logic        acc_en;
      logic        acc_dec;
      logic        start_prefix;
      logic        exp_first;
      logic        exp_more;
      logic        emit;
      logic        clear;
      status_type  status;
      logic [1:0]  held;
   } act_type;

   act_type     act;
   phase_type   next_phase;

   logic        dec_dig;
   logic        is_exp;
   logic        is_us;
   logic        is_dot;
   logic        is_sign;
   logic        is_lhex;
   logic        is_uhex;
   logic        pfx_char;
   radix_type   pfx_radix;
   logic [3:0]  dec_val;
   logic [7:0]  lhex_raw;
   logic [7:0]  uhex_raw;
   logic [3:0]  pfx_val;
   logic        pfx_ok;
   status_type  int_st;
   status_type  pfx_st;

   radix_type   base_sel;
   logic [3:0]  digit_in;
   logic [ACC_W+3:0] acc_ext;
   logic [ACC_W+3:0] acc_wide;
   logic        acc_ovf;
   logic [LEN_W:0] count_sum;

   // Character classes
   assign dec_dig  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign is_exp   = (char_code == CH_LE) || (char_code == CH_UE);
   assign is_us    = (char_code == CH_USCORE);
   assign is_dot   = (char_code == CH_DOT);
   assign is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS);
   assign is_lhex  = (char_code >= CH_LA) && (char_code <= CH_LF);
   assign is_uhex  = (char_code >= CH_UA) && (char_code <= CH_UF);
   assign dec_val  = 4'(char_code - CH_ZERO);
   assign lhex_raw = char_code - CH_LA + 8'd10;
   assign uhex_raw = char_code - CH_UA + 8'd10;

   // Radix prefix letter after a leading zero
   always_comb begin
      pfx_char  = 1'b1;
      pfx_radix = RADIX_DEC;
      if ((char_code == CH_LX) || (char_code == CH_UX)) begin
         pfx_radix = RADIX_HEX;
      end else if ((char_code == CH_LB) || (char_code == CH_UB)) begin
         pfx_radix = RADIX_BIN;
      end else if ((char_code == CH_LO) || (char_code == CH_UO)) begin
         pfx_radix = RADIX_OCT;
      end else begin
         pfx_char = 1'b0;
      end
   end

   // Digit value and validity in the prefixed radix
   always_comb begin
      pfx_val = dec_val;
      if (is_lhex) begin
         pfx_val = lhex_raw[3:0];
      end else if (is_uhex) begin
         pfx_val = uhex_raw[3:0];
      end
      unique case (cur_state.radix)
         RADIX_HEX: pfx_ok = dec_dig || is_lhex || is_uhex;
         RADIX_BIN: pfx_ok = dec_dig && (dec_val < 4'd2);
         RADIX_OCT: pfx_ok = dec_dig && (dec_val < 4'd8);
         default:   pfx_ok = dec_dig;
      endcase
   end

   // Status codes for an integer that ends here
   assign int_st = cur_state.ovf ? ST_OVERFLOW : ST_INT;

   always_comb begin
      if (cur_state.count <= 8'd2) begin
         pfx_st = ST_NO_DIGITS;
      end else if (!cur_state.dseen) begin
         pfx_st = ST_ONLY_UNDERSCORE;
      end else begin
         pfx_st = int_st;
      end
   end

   // Next phase
   always_comb begin
      next_phase = cur_state.phase;
      unique case (cur_state.phase)
         PH_IDLE: begin
            if (!end_flag && dec_dig) begin
               next_phase = (char_code == CH_ZERO) ? PH_ZERO : PH_INT;
            end
         end
         PH_ZERO, PH_INT: begin
            if ((cur_state.phase == PH_ZERO) && !end_flag && pfx_char) begin
               next_phase = PH_PREFIX;
            end else if (end_flag) begin
               next_phase = PH_IDLE;
            end else if (dec_dig || is_us) begin
               next_phase = PH_INT;
            end else if (is_dot) begin
               next_phase = PH_DOT;
            end else if (is_exp) begin
               next_phase = PH_EXP;
            end else begin
               next_phase = PH_IDLE;
            end
         end
         PH_DOT: begin
            next_phase = (!end_flag && dec_dig) ? PH_FRAC : PH_IDLE;
         end
         PH_FRAC: begin
            if (end_flag) begin
               next_phase = PH_IDLE;
            end else if (dec_dig || is_us) begin
               next_phase = PH_FRAC;
            end else if (is_exp) begin
               next_phase = PH_EXP;
            end else begin
               next_phase = PH_IDLE;
            end
         end
         PH_EXP, PH_EXPSIGN: begin
            if (end_flag) begin
               next_phase = PH_IDLE;
            end else if ((cur_state.phase == PH_EXP) && is_sign) begin
               next_phase = PH_EXPSIGN;
            end else if (dec_dig || is_us) begin
               next_phase = PH_EXPDIG;
            end else begin
               next_phase = PH_IDLE;
            end
         end
         PH_EXPDIG: begin
            next_phase = (!end_flag && (dec_dig || is_us)) ? PH_EXPDIG : PH_IDLE;
         end
         PH_PREFIX: begin
            if (end_flag) begin
               next_phase = PH_IDLE;
            end else if (is_us || pfx_ok) begin
               next_phase = PH_PREFIX;
            end else begin
               next_phase = PH_IDLE;
            end
         end
         default: next_phase = PH_IDLE;
      endcase
   end

   // Actions for the character
   always_comb begin
      act        = '0;
      act.status = ST_INT;
      act.held   = HELD_NONE;
      unique case (cur_state.phase)
         PH_IDLE: begin
            if (!end_flag && dec_dig) begin
               act.bump    = 2'd1;
               act.acc_en  = 1'b1;
               act.acc_dec = 1'b1;
            end
         end
         PH_ZERO, PH_INT: begin
            if ((cur_state.phase == PH_ZERO) && !end_flag && pfx_char) begin
               act.bump         = 2'd1;
               act.start_prefix = 1'b1;
            end else if (end_flag) begin
               act.emit   = 1'b1;
               act.status = int_st;
            end else if (dec_dig) begin
               act.bump    = 2'd1;
               act.acc_en  = 1'b1;
               act.acc_dec = 1'b1;
            end else if (is_us || is_exp) begin
               act.bump = 2'd1;
            end else if (!is_dot) begin
               act.emit   = 1'b1;
               act.status = int_st;
               act.held   = HELD_ONE;
            end
         end
         PH_DOT: begin
            if (end_flag) begin
               act.emit   = 1'b1;
               act.status = int_st;
               act.held   = HELD_ONE;
            end else if (dec_dig) begin
               act.bump = 2'd2;
            end else begin
               act.emit   = 1'b1;
               act.status = int_st;
               act.held   = HELD_TWO;
            end
         end
         PH_FRAC: begin
            if (end_flag) begin
               act.emit   = 1'b1;
               act.status = ST_FLOAT;
            end else if (dec_dig || is_us || is_exp) begin
               act.bump = 2'd1;
            end else begin
               act.emit   = 1'b1;
               act.status = ST_FLOAT;
               act.held   = HELD_ONE;
            end
         end
         PH_EXP, PH_EXPSIGN: begin
            if (end_flag) begin
               act.emit   = 1'b1;
               act.status = ST_NO_EXP_DIGITS;
            end else if ((cur_state.phase == PH_EXP) && is_sign) begin
               act.bump = 2'd1;
            end else if (dec_dig || is_us) begin
               act.bump      = 2'd1;
               act.exp_first = 1'b1;
            end else begin
               act.emit   = 1'b1;
               act.status = ST_NO_EXP_DIGITS;
               act.held   = HELD_ONE;
            end
         end
         PH_EXPDIG: begin
            if (!end_flag && (dec_dig || is_us)) begin
               act.bump     = 2'd1;
               act.exp_more = 1'b1;
            end else begin
               act.emit   = 1'b1;
               act.status = cur_state.dseen ? ST_FLOAT : ST_NO_EXP_DIGITS;
               act.held   = end_flag ? HELD_NONE : HELD_ONE;
            end
         end
         PH_PREFIX: begin
            if (end_flag) begin
               act.emit   = 1'b1;
               act.status = pfx_st;
            end else if (is_us) begin
               act.bump = 2'd1;
            end else if (pfx_ok) begin
               act.bump   = 2'd1;
               act.acc_en = 1'b1;
            end else begin
               act.emit   = 1'b1;
               act.status = pfx_st;
               act.held   = HELD_ONE;
            end
         end
         default: act.clear = 1'b1;
      endcase
   end

   // Shift-add accumulator: base times value plus digit, carried into four spare bits
   assign base_sel = act.acc_dec ? RADIX_DEC : cur_state.radix;
   assign digit_in = act.acc_dec ? dec_val : pfx_val;
   assign acc_ext  = {4'b0000, cur_state.acc};

   always_comb begin
      case (base_sel)
         RADIX_HEX: acc_wide = (acc_ext << 4) + (ACC_W+4)'(digit_in);
         RADIX_BIN: acc_wide = (acc_ext << 1) + (ACC_W+4)'(digit_in);
         RADIX_OCT: acc_wide = (acc_ext << 3) + (ACC_W+4)'(digit_in);
         default:   acc_wide = (acc_ext << 3) + (acc_ext << 1) + (ACC_W+4)'(digit_in);
      endcase
   end

   assign acc_ovf   = |acc_wide[ACC_W+3:ACC_W];
   assign count_sum = {1'b0, cur_state.count} + (LEN_W+1)'(act.bump);

   // State update
   always_comb begin
      nxt_state       = cur_state;
      nxt_state.phase = next_phase;
      if (count_sum > {1'b0, len_cap}) begin
         nxt_state.count = len_cap;
      end else begin
         nxt_state.count = count_sum[LEN_W-1:0];
      end
      if (act.acc_en) begin
         nxt_state.dseen = 1'b1;
         if (!cur_state.ovf) begin
            if (acc_ovf) begin
               nxt_state.ovf = 1'b1;
               nxt_state.acc = '0;
            end else begin
               nxt_state.acc = acc_wide[ACC_W-1:0];
            end
         end
      end
      if (act.start_prefix) begin
         nxt_state.radix = pfx_radix;
         nxt_state.acc   = '0;
         nxt_state.dseen = 1'b0;
      end
      if (act.exp_first) begin
         nxt_state.dseen = dec_dig;
      end
      if (act.exp_more && dec_dig) begin
         nxt_state.dseen = 1'b1;
      end
      if (act.emit || act.clear) begin
         nxt_state = STATE_CLEAR;
      end
   end

   // Result item built from the state before this character
   assign emit          = act.emit;
   assign result.status = act.status;
   assign result.radix  = (act.status == ST_FLOAT) ? RADIX_DEC : cur_state.radix;
   assign result.value  = (act.status == ST_INT) ? cur_state.acc : '0;
   assign result.length = cur_state.count;
   assign result.held   = act.held;

endmodule

// ----- design/numeric_literal_scanner.sv -----
// Top level of the numeric literal scanner.
//
// The scanner takes one source character per transfer on req_bus (char_code, or end_flag
// when the source has ended) and recognises one numeric literal that starts with a decimal
// digit: 0x, 0b and 0o prefixed integers, or decimal integers with optional fraction and
// exponent. When the literal ends it gives one transfer on rsp_bus with the status, radix,
// 64-bit integer value, literal length (saturating at MAX_LEN or 255) and the number of
// trailing characters that were seen but not consumed, which the user presents again.
// Characters that do not end a literal give no response.
//
// A transfer on req_bus is registered, evaluated against the scanner state, and its
// response, if any, is registered in the result register that drives rsp_bus.
// Throughput is one character per cycle, set by the single shift-add accumulate and phase
// update between the input register and the state and result registers unless stalled.
// A synchronous reset clears the scanner to idle and empties both registers.
// While rsp_bus is stalled the held response stays put; characters that give no response
// keep flowing, and a character that would give one waits in the input register.
`timescale 1ns / 1ps

module numeric_literal_scanner #(
   parameter int unsigned MAX_LEN = 255
) (
   input  logic              clock,
   input  logic              reset,
   nls_req_if.sink           req_bus,
   nls_rsp_if.source         rsp_bus
);
   import nls_pkg::*;

   localparam logic [LEN_W-1:0] LEN_CAP = (MAX_LEN < 255) ? LEN_W'(MAX_LEN) : 8'd255;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_char_ff;
   logic            in_end_ff;
   nls_state_type   state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   nls_result_type  rsp_data_ff;

   nls_state_type   step_state;
   logic            step_emit;
   nls_result_type  step_result;
   logic            out_free;
   logic            advance;
   logic            req_xfer;

   // Character evaluation
   nls_step u_step (
      .cur_state (state_ff),
      .char_code (in_char_ff),
      .end_flag  (in_end_ff),
      .len_cap   (LEN_CAP),
      .nxt_state (step_state),
      .emit      (step_emit),
      .result    (step_result)
   );

   // Handshake control: the input stage advances unless it needs a busy result register
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign advance       = in_valid_ff && (!step_emit || out_free);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_xfer      = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign state_in     = advance ? step_state : state_ff;
   assign rsp_valid_in = (advance && step_emit) || (rsp_valid_ff && !rsp_bus.ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_char_ff <= req_bus.char_code;
         in_end_ff  <= req_bus.end_flag;
      end
      if (advance && step_emit) begin
         rsp_data_ff <= step_result;
      end
   end

   // Response channel
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_data_ff.status;
   assign rsp_bus.radix_code     = rsp_data_ff.radix;
   assign rsp_bus.int_value      = rsp_data_ff.value;
   assign rsp_bus.literal_length = rsp_data_ff.length;
   assign rsp_bus.held_back      = rsp_data_ff.held;

`ifndef SYNTHESIS
   // A response always returns the scanner to idle
   a_idle_after_emit: assert property (@(posedge clock) disable iff (reset)
      advance && step_emit |=> state_ff.phase == PH_IDLE)
      else $error("scanner not idle after a response");

   // The character count never passes its cap
   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      state_ff.count <= LEN_CAP)
      else $error("character count above cap");

   // Only integer responses carry a value
   a_value_only_int: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != ST_INT) |-> rsp_data_ff.value == '0)
      else $error("non-integer response carries a value");

   // Floats report the decimal radix
   a_float_decimal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == ST_FLOAT) |-> rsp_data_ff.radix == RADIX_DEC)
      else $error("float response with a non-decimal radix");

   // At most two characters are ever held back
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.held != 2'd3)
      else $error("held-back count out of range");
`endif

endmodule
